/* rtl/core/assert_macros.svh */
// Assertion macros used by stereo_feedback_delay.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sfd_pkg.sv */
package sfd_pkg;

  localparam int SMP_W      = 24;
  localparam int ADDR_W     = 18;
  localparam int MAX_DELAY  = 1 << ADDR_W;
  localparam int BASE_W     = 18;
  localparam int GAIN_W     = 16;
  localparam int Q_W        = ADDR_W + 1;
  localparam int MIX_W      = SMP_W + 1;
  localparam int SUM_W      = SMP_W + 3;
  localparam int MUL_W      = 26;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;

  // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every x below 2**22.
  localparam logic [21:0] DIV10_MUL   = 22'd3355444;
  localparam int          DIV10_SHIFT = 25;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD     = 4'd3;

  localparam logic [BASE_W-1:0] RST_DELAY_BASE = 18'd24000;
  localparam logic [GAIN_W-1:0] RST_FEEDBACK   = 16'd0;
  localparam logic [GAIN_W-1:0] RST_WET        = 16'd16384;
  localparam logic [GAIN_W-1:0] RST_SPREAD     = 16'd16384;
  localparam logic [GAIN_W:0]   SPREAD_ONE     = 17'd32768;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
  } sfd_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
  } sfd_out_t;

  // Saturate a widened sum back to a sample.
  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SMP_W-1:0];
    end else if (v < lo) begin
      return lo[SMP_W-1:0];
    end
    return v[SMP_W-1:0];
  endfunction

endpackage

/* rtl/core/sfd_mul.sv */
module sfd_mul
  import sfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  // Product register; it holds while the unit is not in use.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/core/sfd_store.sv */
module sfd_store
  import sfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       addr,
  input  logic signed [SMP_W-1:0] wdata,
  output logic signed [SMP_W-1:0] rdata
);

  logic signed [SMP_W-1:0] mem [MAX_DELAY];
  logic signed [SMP_W-1:0] rdata_r;

  // Single port: one read or one write per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/stereo_feedback_delay.sv */
// A stereo beat is taken only while the sequencer is idle, so a new beat waits until the
// previous result is posted, which can stall on out_ready; the single shared 26x26
// multiplier, used seven times per beat, and the one-port stores set this pace.
// Reset (rst_n, synchronous, active low) restores the register defaults and the write
// pointer; the stores are not swept, a fill flag makes never-written entries read zero.
`include "assert_macros.svh"

module stereo_feedback_delay
  import sfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer states. Each product is consumed by the state after the one
  // that started it.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DL   = 4'd1;  // start base*7/10
  localparam logic [3:0] S_DR   = 4'd2;  // start base*13/10, read left store
  localparam logic [3:0] S_RR   = 4'd3;  // read right store
  localparam logic [3:0] S_MIX  = 4'd4;  // start spread*(dl-dr)
  localparam logic [3:0] S_FBL  = 4'd5;  // start dl*fb, form both mixes
  localparam logic [3:0] S_FBR  = 4'd6;  // start dr*fb, write left store
  localparam logic [3:0] S_WL   = 4'd7;  // start mixl*wet, write right store
  localparam logic [3:0] S_WR   = 4'd8;  // start mixr*wet, take left output
  localparam logic [3:0] S_OR   = 4'd9;  // take right output
  localparam logic [3:0] S_DONE = 4'd10; // post result when the output slot frees

  localparam logic signed [PROD_W-1:0] RND15 = PROD_W'(1) <<< 14;
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(1) <<< 15;

  // Configuration registers.
  logic [BASE_W-1:0]        base_r;
  logic signed [GAIN_W-1:0] fb_r;
  logic [GAIN_W-1:0]        wet_r;
  logic [GAIN_W-1:0]        spread_r;

  // Control state.
  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] wp_r;
  logic              filled_r;
  logic              out_valid_r;
  logic              lvalid_r, rvalid_r;

  // Datapath registers.
  logic signed [SMP_W-1:0] xl_r, xr_r;
  logic signed [SMP_W-1:0] dl_r, dr_r;
  logic signed [MIX_W-1:0] mixl_r, mixr_r;
  logic signed [SMP_W-1:0] ol_r, or_r;
  sfd_out_t                out_data_r;

  // Shared multiplier.
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  // Stores.
  logic                    l_en, l_we, r_en, r_we;
  logic [ADDR_W-1:0]       l_addr, r_addr;
  logic signed [SMP_W-1:0] l_rdata, r_rdata, l_wdata, r_wdata;

  logic              in_fire, out_load;
  logic [20:0]       base7;
  logic [21:0]       base13;
  logic [ADDR_W-1:0] len_q, rd_addr;
  logic              rd_ok;
  logic [GAIN_W:0]   spread_s;
  logic signed [SMP_W-1:0]  dl_now, dr_now;
  logic signed [MIX_W-1:0]  sdiff;
  logic signed [PROD_W-1:0] dsum, mixl_num, mixr_num, rnd15;
  logic signed [SUM_W-1:0]  sum_l, sum_r;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Delay lengths: x*7 and x*13 by shifts, a subtract and adds; the division by ten is a
  // reciprocal multiply on the shared unit.
  assign base7  = ({3'b000, base_r} << 3) - {3'b000, base_r};
  assign base13 = ({4'b0000, base_r} << 3) + ({4'b0000, base_r} << 2) + {4'b0000, base_r};

  // A zero length is raised to one; anything beyond the store is lowered to its last entry.
  function automatic logic [ADDR_W-1:0] clamp_len(input logic [Q_W-1:0] q);
    if (q == '0) begin
      return ADDR_W'(1);
    end else if (q[Q_W-1]) begin
      return {ADDR_W{1'b1}};
    end
    return q[ADDR_W-1:0];
  endfunction

  assign len_q   = clamp_len(prod[DIV10_SHIFT +: Q_W]);
  // The store depth is a power of two, so the pointer difference wraps by itself.
  assign rd_addr = wp_r - len_q;
  // An entry holds data only once it has been written since reset.
  assign rd_ok   = filled_r || (rd_addr < wp_r);

  // Spread above one is clamped to one.
  assign spread_s = ({1'b0, spread_r} > SPREAD_ONE) ? SPREAD_ONE : {1'b0, spread_r};

  assign dl_now = lvalid_r ? l_rdata : '0;
  assign dr_now = rvalid_r ? r_rdata : '0;
  assign sdiff  = MIX_W'(dl_now) - MIX_W'(dr_now);

  // The two cross mixes share one product:
  //   mixl = 32768*(dl+dr) + s*(dl-dr), mixr = 32768*(dl+dr) - s*(dl-dr),
  // both divided by 65536 and rounded half up.
  assign dsum     = PROD_W'(dl_r) + PROD_W'(dr_r);
  assign mixl_num = (dsum <<< 15) + prod + RND16;
  assign mixr_num = (dsum <<< 15) - prod + RND16;

  // Gain products are divided by 32768 and rounded half up.
  assign rnd15 = (prod + RND15) >>> 15;
  assign sum_l = SUM_W'(xl_r) + rnd15[SUM_W-1:0];
  assign sum_r = SUM_W'(xr_r) + rnd15[SUM_W-1:0];
  assign l_wdata = sat_smp(sum_l);
  assign r_wdata = sat_smp(sum_r);

  // Multiplier operand selection.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_DL: begin
        mul_a = MUL_W'(base7);
        mul_b = MUL_W'(DIV10_MUL);
      end
      S_DR: begin
        mul_a = MUL_W'(base13);
        mul_b = MUL_W'(DIV10_MUL);
      end
      S_MIX: begin
        mul_a = MUL_W'(sdiff);
        mul_b = MUL_W'(spread_s);
      end
      S_FBL: begin
        mul_a = MUL_W'(dl_r);
        mul_b = MUL_W'(fb_r);
      end
      S_FBR: begin
        mul_a = MUL_W'(dr_r);
        mul_b = MUL_W'(fb_r);
      end
      S_WL: begin
        mul_a = MUL_W'(mixl_r);
        mul_b = MUL_W'(wet_r);
      end
      S_WR: begin
        mul_a = MUL_W'(mixr_r);
        mul_b = MUL_W'(wet_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Store port control. Reads come before the write of the same beat, so an
  // entry read is always one written on an earlier beat.
  assign l_en   = (state_r == S_DR) || (state_r == S_FBR);
  assign l_we   = (state_r == S_FBR);
  assign l_addr = l_we ? wp_r : rd_addr;
  assign r_en   = (state_r == S_RR) || (state_r == S_WL);
  assign r_we   = (state_r == S_WL);
  assign r_addr = r_we ? wp_r : rd_addr;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = in_fire ? S_DL : S_IDLE;
      S_DL:    state_nxt = S_DR;
      S_DR:    state_nxt = S_RR;
      S_RR:    state_nxt = S_MIX;
      S_MIX:   state_nxt = S_FBL;
      S_FBL:   state_nxt = S_FBR;
      S_FBR:   state_nxt = S_WL;
      S_WL:    state_nxt = S_WR;
      S_WR:    state_nxt = S_OR;
      S_OR:    state_nxt = S_DONE;
      S_DONE:  state_nxt = out_load ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      filled_r    <= 1'b0;
      out_valid_r <= 1'b0;
      lvalid_r    <= 1'b0;
      rvalid_r    <= 1'b0;
      base_r      <= RST_DELAY_BASE;
      fb_r        <= RST_FEEDBACK;
      wet_r       <= RST_WET;
      spread_r    <= RST_SPREAD;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DR) begin
        lvalid_r <= rd_ok;
      end
      if (state_r == S_RR) begin
        rvalid_r <= rd_ok;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        wp_r        <= wp_r + ADDR_W'(1);
        if (wp_r == {ADDR_W{1'b1}}) begin
          filled_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Writes to indexes beyond the register list fall through and are dropped.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DELAY_BASE: base_r   <= cfg_data[BASE_W-1:0];
          REG_FEEDBACK:   fb_r     <= cfg_data[GAIN_W-1:0];
          REG_WET:        wet_r    <= cfg_data[GAIN_W-1:0];
          REG_SPREAD:     spread_r <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      xl_r <= in_data.left_in;
      xr_r <= in_data.right_in;
    end
    if (state_r == S_MIX) begin
      dl_r <= dl_now;
      dr_r <= dr_now;
    end
    if (state_r == S_FBL) begin
      mixl_r <= MIX_W'(mixl_num >>> 16);
      mixr_r <= MIX_W'(mixr_num >>> 16);
    end
    if (state_r == S_WR) begin
      ol_r <= l_wdata;
    end
    if (state_r == S_OR) begin
      or_r <= r_wdata;
    end
    if (out_load) begin
      out_data_r.left_out  <= ol_r;
      out_data_r.right_out <= or_r;
    end
  end

  sfd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sfd_store u_left_store (
    .clk   (clk),
    .en    (l_en),
    .we    (l_we),
    .addr  (l_addr),
    .wdata (l_wdata),
    .rdata (l_rdata)
  );

  sfd_store u_right_store (
    .clk   (clk),
    .en    (r_en),
    .we    (r_we),
    .addr  (r_addr),
    .wdata (r_wdata),
    .rdata (r_rdata)
  );

  // The sequencer must leave idle as soon as a beat is taken.
  `SFD_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "ready after accepted beat")
  // The write pointer moves by exactly one per posted result.
  `SFD_ASSERT_NXT(a_wp_step, out_load, wp_r == $past(wp_r) + ADDR_W'(1), "pointer step")
  // Once the stores have wrapped, every entry holds written data until reset.
  `SFD_ASSERT_NXT(a_filled_sticky, filled_r, filled_r, "fill flag dropped")

endmodule
